/* src/wcfb_pkg.sv */
`default_nettype none
package wcfb_pkg;

  localparam int MAX_BYTES = 32;
  localparam int ADDR_W    = $clog2(MAX_BYTES);
  localparam int CHIPS_W   = 64;

  typedef logic [CHIPS_W-1:0] chips_t;
  typedef logic [2:0]         part_t;
  typedef logic [1:0]         cfg_idx_t;

  // register indexes on the configuration port
  localparam cfg_idx_t REG_CODE_LOG2      = 2'd0;
  localparam cfg_idx_t REG_PREAMBLE_WORDS = 2'd1;
  localparam cfg_idx_t REG_PAYLOAD_BYTES  = 2'd2;

  // frame part codes
  localparam part_t PART_PREAMBLE = 3'd0;
  localparam part_t PART_SFD      = 3'd1;
  localparam part_t PART_CODE     = 3'd2;
  localparam part_t PART_LENGTH   = 3'd3;
  localparam part_t PART_PAYLOAD  = 3'd4;

  // chips 0 .. L/2-1 set, L = 2^k
  function automatic chips_t half_ones(logic [2:0] k);
    chips_t w;
    for (int j = 0; j < CHIPS_W; j++) begin
      w[j] = (j < ((1 << k) >> 1));
    end
    return w;
  endfunction

  // chip j is the parity of row AND j, only chips below L = 2^k
  function automatic chips_t walsh_row(logic [5:0] row, logic [2:0] k);
    chips_t w;
    logic [5:0] j6;
    for (int j = 0; j < CHIPS_W; j++) begin
      j6 = 6'(j);
      w[j] = (^(row & j6)) & (j < (1 << k));
    end
    return w;
  endfunction

endpackage
`default_nettype wire

/* src/wcfb_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle; divisor is 1..6.
module wcfb_div (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [8:0] dividend,
  input  wire logic [2:0] divisor,
  output logic [8:0]      quotient,
  output logic            done
);
  import wcfb_pkg::*;

  logic [8:0] dvd;
  logic [2:0] rem;
  logic [2:0] dsr;
  logic [3:0] cnt;
  logic       running;
  logic [3:0] trial;
  logic       fits;

  assign trial    = {rem, dvd[8]};
  assign fits     = (trial >= {1'b0, dsr});
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= 4'd9;
      end else if (running) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      if (fits) begin
        rem <= 3'(trial - {1'b0, dsr});
        dvd <= {dvd[7:0], 1'b1};
      end else begin
        rem <= trial[2:0];
        dvd <= {dvd[7:0], 1'b0};
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !running)
    else $error("divider done while still running");
  assert property (@(posedge clk) disable iff (rst) start |=> running)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) running |-> (cnt != 4'd0))
    else $error("divider count underflow");

endmodule
`default_nettype wire

/* src/walsh_code_frame_builder.sv */
`default_nettype none
// Walsh code frame builder.
// Command channel: an item is taken at a clock edge with start high and busy low.
// func = 0 stores data_byte as the next payload byte (up to 32 per frame); it
// finishes in that edge and busy stays low. func = 1 pulls the next codeword of
// the frame: busy stays high while it runs, and done pulses for one cycle as
// busy falls, with chips, frame_part and last valid in that cycle. The next
// item may be taken at the edge that takes the result. A pull runs the
// 9-step bit serial divider that forms the index count, then position,
// multiply, two byte-store reads and the output register.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them while the block is idle, and the block does not enforce this.
// Reset sets code_log2 = 2, preamble_words = 8, payload_bytes = 1 and
// empties the frame; the byte store holds no defined data until loaded.
// After the last word of a frame the position and byte count start over.
module walsh_code_frame_builder (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              func,
  input  wire logic [7:0]        data_byte,
  input  wire logic              cfg_we,
  input  wire wcfb_pkg::cfg_idx_t cfg_index,
  input  wire logic [7:0]        cfg_data,
  output logic                   done,
  output wcfb_pkg::chips_t       chips,
  output wcfb_pkg::part_t        frame_part,
  output logic                   last
);
  import wcfb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_POS  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_RD0  = 3'd4;
  localparam logic [2:0] ST_RD1  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]  state;
  logic [2:0]  code_log2;
  logic [7:0]  preamble_words;
  logic [5:0]  payload_bytes;
  logic [5:0]  bytes_loaded;
  logic [9:0]  word_position;
  logic [8:0]  index_total;

  logic [7:0]  byte_store [MAX_BYTES];
  logic [7:0]  rd_data;
  logic [7:0]  byte0;
  logic [ADDR_W-1:0] rd_addr;

  logic [9:0]  pos;
  logic        pos_last;
  logic [7:0]  start_bit;
  logic [2:0]  grp_len;

  logic [2:0]  k_eff;
  logic [5:0]  n_eff;
  logic [8:0]  payload_bits;
  logic [8:0]  dividend;
  logic        div_start;
  logic        div_done;
  logic [8:0]  div_q;

  logic [9:0]  total_words;
  logic [9:0]  last_pos;
  logic [9:0]  rel;
  logic [7:0]  m;
  logic [10:0] prod;
  logic [8:0]  bits_left;
  logic [15:0] window;
  logic [3:0]  sh;
  logic [15:0] shifted;
  logic [5:0]  grp_val;
  logic [1:0]  code_sel;
  logic [2:0]  len_sel;
  chips_t      half;
  chips_t      chips_next;
  part_t       part_next;

  always_comb begin
    if (code_log2 == 3'd0)      k_eff = 3'd1;
    else if (code_log2 == 3'd7) k_eff = 3'd6;
    else                        k_eff = code_log2;
    if (payload_bytes == 6'd0)                     n_eff = 6'd1;
    else if (payload_bytes > 6'(MAX_BYTES))        n_eff = 6'(MAX_BYTES);
    else                                           n_eff = payload_bytes;
  end

  assign payload_bits = {n_eff, 3'b000};
  assign dividend     = 9'(payload_bits + 9'(k_eff) - 9'd1);
  assign busy         = (state != ST_IDLE);
  assign div_start    = (state == ST_IDLE) && start && func;

  wcfb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (k_eff),
    .quotient (div_q),
    .done     (div_done)
  );

  // position arithmetic
  assign total_words = 10'(preamble_words) + 10'd12 + 10'(index_total);
  assign last_pos    = total_words - 10'd1;
  assign rel         = pos - 10'(preamble_words);
  assign m           = 8'(rel - 10'd12);
  assign prod        = 11'(m) * 11'(k_eff);
  assign bits_left   = payload_bits - 9'(start_bit);
  assign rd_addr     = (state == ST_RD1) ? ADDR_W'(start_bit[7:3] + 5'd1)
                                         : start_bit[7:3];

  // payload group from the two bytes that hold it
  assign window  = {byte0, rd_data};
  assign sh      = 4'(5'd16 - 5'(start_bit[2:0]) - 5'(grp_len));
  assign shifted = window >> sh;
  assign grp_val = shifted[5:0] & 6'((7'd1 << grp_len) - 7'd1);
  assign half    = half_ones(k_eff);
  assign code_sel = 2'(rel - 10'd1);
  assign len_sel  = 3'(rel - 10'd4);

  always_comb begin
    if (pos < 10'(preamble_words)) begin
      part_next  = PART_PREAMBLE;
      chips_next = half;
    end else if (rel == 10'd0) begin
      part_next  = PART_SFD;
      chips_next = '0;
    end else if (rel < 10'd4) begin
      part_next  = PART_CODE;
      chips_next = k_eff[2'd2 - code_sel] ? half : '0;
    end else if (rel < 10'd12) begin
      part_next  = PART_LENGTH;
      chips_next = index_total[4'd7 - 4'(len_sel)] ? half : '0;
    end else begin
      part_next  = PART_PAYLOAD;
      chips_next = walsh_row(grp_val, k_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      code_log2      <= 3'd2;
      preamble_words <= 8'd8;
      payload_bytes  <= 6'd1;
      bytes_loaded   <= '0;
      word_position  <= '0;
      index_total    <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_CODE_LOG2:      code_log2      <= cfg_data[2:0];
          REG_PREAMBLE_WORDS: preamble_words <= cfg_data;
          REG_PAYLOAD_BYTES:  payload_bytes  <= cfg_data[5:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (start && !func && (bytes_loaded < 6'(MAX_BYTES))) begin
            bytes_loaded <= bytes_loaded + 6'd1;
          end
          if (start && func) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            index_total <= div_q;
            state       <= ST_POS;
          end
        end
        ST_POS: state <= ST_MUL;
        ST_MUL: state <= ST_RD0;
        ST_RD0: state <= ST_RD1;
        ST_RD1: state <= ST_OUT;
        ST_OUT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (pos_last) begin
            word_position <= '0;
            bytes_loaded  <= '0;
          end else begin
            word_position <= pos + 10'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_POS) begin
      pos      <= (word_position > last_pos) ? last_pos : word_position;
      pos_last <= (word_position >= last_pos);
    end
    if (state == ST_MUL) begin
      start_bit <= prod[7:0];
    end
    if (state == ST_RD0) begin
      grp_len <= (bits_left < 9'(k_eff)) ? bits_left[2:0] : k_eff;
    end
    if (state == ST_RD1) begin
      byte0 <= rd_data;
    end
    if (state == ST_OUT) begin
      chips      <= chips_next;
      frame_part <= part_next;
      last       <= pos_last;
    end
  end

  // byte store
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start && !func && (bytes_loaded < 6'(MAX_BYTES))) begin
      byte_store[bytes_loaded[ADDR_W-1:0]] <= data_byte;
    end
    rd_data <= byte_store[rd_addr];
  end

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result beat longer than one cycle");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state == ST_OUT))
    else $error("result beat without a finished pull");
  assert property (@(posedge clk) disable iff (rst)
    (done && last) |-> (word_position == 10'd0 && bytes_loaded == 6'd0))
    else $error("frame did not restart after last word");
  assert property (@(posedge clk) disable iff (rst) bytes_loaded <= 6'(MAX_BYTES))
    else $error("byte count beyond store depth");

endmodule
`default_nettype wire

/* bench/tb_walsh_code_frame_builder.sv */
`timescale 1ns / 100ps

module tb_walsh_code_frame_builder;
  import wcfb_pkg::*;

  localparam int       SETTLE_CYCLES  = 20;
  localparam int       END_CYCLES     = 40;
  localparam int       WATCHDOG_LIMIT = 1000;
  localparam int       RANDOM_ITEMS   = 650;
  localparam cfg_idx_t REG_SPARE      = 2'd3;

  typedef struct packed {
    chips_t chips;
    part_t  part;
    logic   last;
  } codeword_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       func;
  logic [7:0] data_byte;
  logic       cfg_we;
  cfg_idx_t   cfg_index;
  logic [7:0] cfg_data;
  logic       done;
  chips_t     chips;
  part_t      frame_part;
  logic       last;

  // frame state as the block should hold it
  logic [2:0]  code_log2_r  = 3'd2;
  logic [7:0]  preamble_r   = 8'd8;
  logic [5:0]  payload_r    = 6'd1;
  logic [7:0]  byte_store_m [MAX_BYTES];
  bit          written_m    [MAX_BYTES];
  int unsigned bytes_loaded_m = 0;
  int unsigned word_pos_m     = 0;

  codeword_t   pending_codewords[$];
  int unsigned beats_sent  = 0;
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  bit          sender_gaps = 1'b1;

  walsh_code_frame_builder DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .data_byte  (data_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .chips      (chips),
    .frame_part (frame_part),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_code_log2();
    if (code_log2_r == 3'd0) return 1;
    if (code_log2_r == 3'd7) return 6;
    return code_log2_r;
  endfunction

  function automatic int unsigned eff_payload_bytes();
    if (payload_r == 6'd0) return 1;
    if (payload_r > MAX_BYTES) return MAX_BYTES;
    return payload_r;
  endfunction

  function automatic int unsigned frame_words();
    int unsigned k;
    int unsigned nbits;
    k = eff_code_log2();
    nbits = 8 * eff_payload_bytes();
    return preamble_r + 12 + (nbits + k - 1) / k;
  endfunction

  // pulls still needed to reach the last word of the current frame
  function automatic int unsigned words_left();
    int unsigned total;
    total = frame_words();
    if (word_pos_m >= total - 1) return 1;
    return total - word_pos_m;
  endfunction

  // leading store entries that hold loaded data
  function automatic int unsigned filled_prefix();
    int unsigned c;
    c = 0;
    while (c < MAX_BYTES && written_m[c]) c++;
    return c;
  endfunction

  function automatic chips_t half_chips(int unsigned k);
    chips_t w;
    w = '0;
    for (int j = 0; j < ((1 << k) >> 1); j++) w[j] = 1'b1;
    return w;
  endfunction

  function automatic chips_t walsh_chips(int unsigned row, int unsigned k);
    chips_t w;
    w = '0;
    for (int unsigned j = 0; j < (1 << k); j++) w[j] = $countones(row & j) & 1;
    return w;
  endfunction

  // k-bit MSB-first group m of the payload bits, short tail right-aligned
  function automatic int unsigned payload_group(int unsigned m, int unsigned k,
                                                int unsigned nbits);
    int unsigned first;
    int unsigned stop;
    int unsigned v;
    first = m * k;
    stop = first + k;
    if (stop > nbits) stop = nbits;
    v = 0;
    for (int unsigned b = first; b < stop; b++) begin
      v = (v << 1) | byte_store_m[b >> 3][7 - (b & 7)];
    end
    return v;
  endfunction

  function automatic void store_byte(logic [7:0] b);
    if (bytes_loaded_m < MAX_BYTES) begin
      byte_store_m[bytes_loaded_m] = b;
      written_m[bytes_loaded_m] = 1'b1;
      bytes_loaded_m++;
    end
  endfunction

  function automatic codeword_t next_codeword();
    codeword_t   cw;
    int unsigned k;
    int unsigned nbits;
    int unsigned index_cnt;
    int unsigned p;
    int unsigned total;
    int unsigned pos;
    k = eff_code_log2();
    nbits = 8 * eff_payload_bytes();
    index_cnt = (nbits + k - 1) / k;
    p = preamble_r;
    total = p + 12 + index_cnt;
    // hold a position past a shortened frame at its final word
    pos = (word_pos_m > total - 1) ? total - 1 : word_pos_m;
    cw.chips = '0;
    cw.last = 1'b0;
    if (pos < p) begin
      cw.chips = half_chips(k);
      cw.part = PART_PREAMBLE;
    end else if (pos == p) begin
      cw.part = PART_SFD;
    end else if (pos < p + 4) begin
      if ((k >> (3 - (pos - p))) & 1) cw.chips = half_chips(k);
      cw.part = PART_CODE;
    end else if (pos < p + 12) begin
      if ((index_cnt >> (11 - (pos - p))) & 1) cw.chips = half_chips(k);
      cw.part = PART_LENGTH;
    end else begin
      cw.chips = walsh_chips(payload_group(pos - p - 12, k, nbits), k);
      cw.part = PART_PAYLOAD;
    end
    if (pos == total - 1) begin
      cw.last = 1'b1;
      word_pos_m = 0;
      bytes_loaded_m = 0;
    end else begin
      word_pos_m = pos + 1;
    end
    return cw;
  endfunction

  // leave start high on return so back-to-back beats need no second assignment
  task automatic send_item(logic f, logic [7:0] b);
    start <= 1'b1;
    func <= f;
    data_byte <= b;
    do @(posedge clk); while (busy);
    if (f) pending_codewords.push_back(next_codeword());
    else store_byte(b);
    beats_sent++;
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (sender_gaps && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 13));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_codewords.size() != 0) @(posedge clk);
  endtask

  // a load gives no result beat, so allow a full pull time after the drain
  task automatic settle_block();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    case (idx)
      REG_CODE_LOG2:      code_log2_r = d[2:0];
      REG_PREAMBLE_WORDS: preamble_r = d;
      REG_PAYLOAD_BYTES:  payload_r = d[5:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [7:0] code_raw, logic [7:0] pre_raw,
                              logic [7:0] pay_raw);
    settle_block();
    write_reg(REG_CODE_LOG2, code_raw);
    write_reg(REG_PREAMBLE_WORDS, pre_raw);
    write_reg(REG_PAYLOAD_BYTES, pay_raw);
    cfg_we <= 1'b0;
  endtask

  task automatic pull_frame_end();
    repeat (words_left()) begin
      maybe_gap();
      send_item(1'b1, 8'($urandom));
    end
  endtask

  task automatic test_default_frame();
    send_item(1'b0, 8'hFF);
    pull_frame_end();
  endtask

  task automatic test_code_size_limits();
    // k of zero runs as one, payload size of zero as one byte
    program_regs(8'hF8, 8'h00, 8'hC0);
    send_item(1'b0, 8'h00);
    pull_frame_end();
    // k of seven runs as six: 64 chips, short final group
    program_regs(8'h07, 8'h01, 8'h01);
    send_item(1'b0, 8'h9E);
    pull_frame_end();
  endtask

  task automatic test_reconfig_mid_frame();
    program_regs(8'h03, 8'hFF, 8'h02);
    send_item(1'b0, 8'h5A);
    send_item(1'b0, 8'hC3);
    repeat (20) begin
      maybe_gap();
      send_item(1'b1, 8'($urandom));
    end
    // shrink the frame under the current position: expect the final word
    program_regs(8'h03, 8'h00, 8'h02);
    send_item(1'b1, 8'($urandom));
    send_item(1'b1, 8'($urandom));
  endtask

  task automatic test_spare_index();
    settle_block();
    write_reg(REG_SPARE, 8'($urandom));
    cfg_we <= 1'b0;
    send_item(1'b0, 8'($urandom));
    pull_frame_end();
  endtask

  task automatic run_frame();
    int unsigned n_eff;
    int unsigned load_min;
    int unsigned load_cnt;
    int unsigned pull_cnt;
    n_eff = eff_payload_bytes();
    // never let a payload word read a store entry that was not loaded
    load_min = (filled_prefix() >= n_eff) ? 0 : n_eff - bytes_loaded_m;
    case ($urandom_range(0, 9))
      0:       load_cnt = load_min;
      1:       load_cnt = load_min + $urandom_range(1, 4);
      default: load_cnt = (n_eff > bytes_loaded_m) ? n_eff - bytes_loaded_m : 0;
    endcase
    repeat (load_cnt) begin
      maybe_gap();
      send_item(1'b0, 8'($urandom));
    end
    pull_cnt = words_left();
    if ($urandom_range(0, 7) == 0) pull_cnt = $urandom_range(1, pull_cnt);
    repeat (pull_cnt) begin
      maybe_gap();
      if (sender_gaps && $urandom_range(0, 31) == 0) wait_drained();
      if ($urandom_range(0, 19) == 0) send_item(1'b0, 8'($urandom));
      send_item(1'b1, 8'($urandom));
    end
  endtask

  task automatic test_random_frames();
    int unsigned first;
    int unsigned frame_no;
    bit          tail_part;
    first = beats_sent;
    frame_no = 0;
    while (beats_sent - first < RANDOM_ITEMS) begin
      // no idling and no reprogramming in the last part of the run
      tail_part = (beats_sent - first >= RANDOM_ITEMS - 100);
      sender_gaps = !tail_part && ($urandom_range(0, 2) != 0);
      if (frame_no == 1) begin
        // most payload words: k = 1, 32 bytes, index count wraps the length field
        program_regs(8'h09, 8'h00, 8'h20);
        repeat (MAX_BYTES + 2 - bytes_loaded_m) send_item(1'b0, 8'($urandom));
      end else if (!tail_part && $urandom_range(0, 2) == 0) begin
        program_regs(8'($urandom),
                     ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)),
                     {2'($urandom), ($urandom_range(0, 7) == 0) ?
                       6'($urandom_range(32, 63)) : 6'($urandom_range(0, 6))});
      end
      run_frame();
      frame_no++;
    end
  endtask

  always @(posedge clk) begin : check_results
    codeword_t want;
    if (!rst && done) begin
      if (pending_codewords.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual chips %h part %0d last %b",
                 $time, chips, frame_part, last);
        mismatches++;
      end else begin
        want = pending_codewords.pop_front();
        if (chips !== want.chips) begin
          $display("%0t: chips expected %h actual %h", $time, want.chips, chips);
          mismatches++;
        end
        if (frame_part !== want.part) begin
          $display("%0t: frame_part expected %0d actual %0d", $time, want.part, frame_part);
          mismatches++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    func <= 1'b0;
    data_byte <= 8'h00;
    cfg_we <= 1'b0;
    cfg_index <= REG_CODE_LOG2;
    cfg_data <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_default_frame();
    test_code_size_limits();
    test_reconfig_mid_frame();
    test_spare_index();
    test_random_frames();
    start <= 1'b0;
    @(posedge clk);
    while (pending_codewords.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* walsh_code_frame_builder.f */
src/wcfb_pkg.sv
src/wcfb_div.sv
src/walsh_code_frame_builder.sv
bench/tb_walsh_code_frame_builder.sv
